// File: hdl/lpfd_pkg.sv
package lpfd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  localparam logic OUT_KIND_PAYLOAD   = 1'b0;
  localparam logic OUT_KIND_FRAME_END = 1'b1;

  // One result item as it travels from the parser to the output buffer.
  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [15:0] msg_type;
    logic [31:0] msg_length;
    logic        crc_ok;
  } lpfd_result_t;

  // Reflected CRC-32 update over one byte; unrolls to an XOR network.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/lpfd_parser.sv
module lpfd_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  output logic                  res_valid,
  output lpfd_pkg::lpfd_result_t res
);
  import lpfd_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_TYPE1  = 4'd1,
    PH_TYPE2  = 4'd2,
    PH_LEN1   = 4'd3,
    PH_LEN2   = 4'd4,
    PH_LEN3   = 4'd5,
    PH_LEN4   = 4'd6,
    PH_DATA   = 4'd7,
    PH_CRC1   = 4'd8,
    PH_CRC2   = 4'd9,
    PH_CRC3   = 4'd10,
    PH_CRC4   = 4'd11
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] running_crc, running_crc_next;
  logic [15:0] frame_type, frame_type_next;
  logic [31:0] frame_length, frame_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] received_crc, received_crc_next;
  logic [31:0] crc_upd;
  logic [31:0] left_dec;
  logic [31:0] rx_crc_full;

  assign crc_upd     = crc32_byte(running_crc, in_byte);
  assign left_dec    = bytes_left - 32'd1;
  assign rx_crc_full = {received_crc[31:8], in_byte};

  always_comb begin
    phase_next        = phase;
    running_crc_next  = running_crc;
    frame_type_next   = frame_type;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    received_crc_next = received_crc;
    res_valid         = 1'b0;
    res.kind          = OUT_KIND_PAYLOAD;
    res.payload_byte  = 8'd0;
    res.msg_type      = frame_type;
    res.msg_length    = frame_length;
    res.crc_ok        = 1'b0;
    unique case (phase)
      PH_TYPE1: begin
        frame_type_next  = {in_byte, 8'd0};
        running_crc_next = crc_upd;
        phase_next       = PH_TYPE2;
      end
      PH_TYPE2: begin
        frame_type_next  = {frame_type[15:8], in_byte};
        running_crc_next = crc_upd;
        phase_next       = PH_LEN1;
      end
      PH_LEN1: begin
        frame_length_next = {in_byte, 24'd0};
        running_crc_next  = crc_upd;
        phase_next        = PH_LEN2;
      end
      PH_LEN2: begin
        frame_length_next = {frame_length[31:24], in_byte, 16'd0};
        running_crc_next  = crc_upd;
        phase_next        = PH_LEN3;
      end
      PH_LEN3: begin
        frame_length_next = {frame_length[31:16], in_byte, 8'd0};
        running_crc_next  = crc_upd;
        phase_next        = PH_LEN4;
      end
      PH_LEN4: begin
        frame_length_next = {frame_length[31:8], in_byte};
        bytes_left_next   = {frame_length[31:8], in_byte};
        running_crc_next  = crc_upd;
        if ({frame_length[31:8], in_byte} != 32'd0) begin
          phase_next = PH_DATA;
        end else begin
          phase_next = PH_CRC1;
        end
      end
      PH_DATA: begin
        running_crc_next = crc_upd;
        bytes_left_next  = left_dec;
        if (left_dec == 32'd0) begin
          phase_next = PH_CRC1;
        end
        res_valid        = 1'b1;
        res.payload_byte = in_byte;
      end
      PH_CRC1: begin
        received_crc_next = {in_byte, 24'd0};
        phase_next        = PH_CRC2;
      end
      PH_CRC2: begin
        received_crc_next = {received_crc[31:24], in_byte, 16'd0};
        phase_next        = PH_CRC3;
      end
      PH_CRC3: begin
        received_crc_next = {received_crc[31:16], in_byte, 8'd0};
        phase_next        = PH_CRC4;
      end
      PH_CRC4: begin
        received_crc_next = rx_crc_full;
        res_valid         = 1'b1;
        res.kind          = OUT_KIND_FRAME_END;
        res.crc_ok        = (rx_crc_full == running_crc);
        phase_next        = PH_HEADER;
        running_crc_next  = 32'd0;
        bytes_left_next   = 32'd0;
      end
      default: begin
        // Hunting for the header; unused phase codes behave the same way.
        // The CRC of a single zero byte from a zero start is zero.
        running_crc_next = 32'd0;
        if (in_byte != 8'd0) begin
          phase_next      = PH_HEADER;
          bytes_left_next = 32'd0;
        end else begin
          phase_next = PH_TYPE1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      running_crc  <= 32'd0;
      frame_type   <= 16'd0;
      frame_length <= 32'd0;
      bytes_left   <= 32'd0;
      received_crc <= 32'd0;
    end else if (take) begin
      phase        <= phase_next;
      running_crc  <= running_crc_next;
      frame_type   <= frame_type_next;
      frame_length <= frame_length_next;
      bytes_left   <= bytes_left_next;
      received_crc <= received_crc_next;
    end
  end

endmodule

// File: hdl/lpfd_out_buf.sv
module lpfd_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lpfd_pkg::lpfd_result_t din,
  output logic                  space,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lpfd_pkg::lpfd_result_t dout
);
  import lpfd_pkg::*;

  logic         main_valid;
  logic         skid_valid;
  lpfd_result_t main_data;
  lpfd_result_t skid_data;
  logic         drain;

  // The main register can take a new entry when it is empty or being read.
  assign drain     = !main_valid || out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign dout      = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid) begin
        main_data <= skid_data;
        if (push) begin
          skid_data <= din;
        end
      end else if (push) begin
        main_data <= din;
      end
    end else if (push) begin
      skid_data <= din;
    end
  end

endmodule

// File: hdl/length_prefixed_frame_deframer_crc32.sv
// Length-prefixed frame deframer with CRC-32 check. Bytes of the received
// stream enter one per request on the input channel; frames are a zero header
// byte, a big-endian 16-bit type, a big-endian 32-bit payload length, the
// payload and a big-endian 32-bit CRC. Nonzero bytes seen while hunting for
// the header are dropped. Every payload byte leaves as a request with out_kind
// low, and after the last CRC byte one request with out_kind high carries the
// type, the length and crc_ok. The CRC is the reflected CRC-32 (polynomial
// 0xEDB88320) over header, type, length and payload, starting from zero with
// no final inversion. The block takes one byte every clock cycle while
// in_ready is high: the bytewise CRC update and the parser state advance in
// the same cycle the byte is accepted, and each result is registered before it leaves.
// A two-entry output buffer keeps in_ready free of any path from out_ready, so
// in_ready drops only when two results wait unread.
module length_prefixed_frame_deframer_crc32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] msg_type,
  output logic [31:0] msg_length,
  output logic        crc_ok
);
  import lpfd_pkg::*;

  logic         take;
  logic         res_valid;
  lpfd_result_t res;
  lpfd_result_t out_data;
  logic         space;

  // A byte is taken whenever the output buffer has a free entry, whether or
  // not this byte will produce a result.
  assign in_ready = space;
  assign take     = in_valid && in_ready;

  lpfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take && res_valid),
    .din       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (out_data)
  );

  // Unpack the buffered result onto the individual output ports.
  assign out_kind     = out_data.kind;
  assign payload_byte = out_data.payload_byte;
  assign msg_type     = out_data.msg_type;
  assign msg_length   = out_data.msg_length;
  assign crc_ok       = out_data.crc_ok;

endmodule
